>>> hw/rtl/tdt_pkg.sv
// Shared types and constants of the triangle deduplication table.
package tdt_pkg;

  // Fixed field widths of the item and result beats.
  localparam int VERT_W  = 10;
  localparam int ENTRY_W = 3 * VERT_W;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  // Operation codes of an input beat.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } tdt_op_t;

  // Status codes of a result beat.
  typedef enum logic [2:0] {
    STAT_ADDED      = 3'd0,
    STAT_DEGENERATE = 3'd1,
    STAT_DUPLICATE  = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_CLEARED    = 3'd4
  } tdt_status_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } tdt_state_t;

  // One finished result as handed from the sequencer to the output register.
  typedef struct packed {
    tdt_status_t        status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } tdt_res_t;

endpackage

>>> hw/rtl/tdt_if.sv
// Valid/ready channel interfaces for the item and result beats.
interface tdt_in_if;
  import tdt_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [VERT_W-1:0] vert_a;
  logic [VERT_W-1:0] vert_b;
  logic [VERT_W-1:0] vert_c;

  modport source (output valid, output operation, output vert_a, output vert_b,
                  output vert_c, input ready);
  modport sink   (input valid, input operation, input vert_a, input vert_b,
                  input vert_c, output ready);
endinterface

interface tdt_out_if;
  import tdt_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output status, output slot, output count, input ready);
  modport sink   (input valid, input status, input slot, input count, output ready);
endinterface

>>> hw/rtl/tdt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tdt_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/tdt_ctrl.sv
// Sequencer that sweeps the triangle memory, compares entries and appends new triangles.
module tdt_ctrl #(
  parameter int MAX_FACES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  tdt_in_if.sink            in_ch,
  output logic              res_valid,
  input  logic              res_ready,
  output tdt_pkg::tdt_res_t res_o
);
  import tdt_pkg::*;

  localparam int AW = $clog2(MAX_FACES);
  localparam int CW = $clog2(MAX_FACES + 1);

  tdt_state_t         state_r, state_nxt;
  logic [VERT_W-1:0]  a_r, a_nxt;
  logic [VERT_W-1:0]  b_r, b_nxt;
  logic [VERT_W-1:0]  c_r, c_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  tdt_status_t        status_r, status_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;

  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [VERT_W-1:0]  ent_p, ent_q, ent_r;
  logic               hit;
  logic               degenerate;
  logic [31:0]        cmp_idx_ext;
  logic [31:0]        count_ext;

  // Triangle memory: a in the low bits, then b, then c.
  tdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_FACES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({c_r, b_r, a_r}),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Set comparison of the entry read last cycle against the held triangle.
  assign ent_p = ram_rdata[VERT_W-1:0];
  assign ent_q = ram_rdata[2*VERT_W-1:VERT_W];
  assign ent_r = ram_rdata[3*VERT_W-1:2*VERT_W];
  assign hit = ((ent_p == a_r) || (ent_p == b_r) || (ent_p == c_r)) &&
               ((ent_q == a_r) || (ent_q == b_r) || (ent_q == c_r)) &&
               ((ent_r == a_r) || (ent_r == b_r) || (ent_r == c_r));

  assign degenerate = (in_ch.vert_a == in_ch.vert_b) || (in_ch.vert_b == in_ch.vert_c) ||
                      (in_ch.vert_c == in_ch.vert_a);

  // Slot and count are reported truncated to the result field widths.
  assign cmp_idx_ext = 32'(cmp_idx_r);
  assign count_ext   = 32'(count_r);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_EMIT);
  assign res_o.status = status_r;
  assign res_o.slot   = slot_r;
  assign res_o.count  = count_ext[COUNT_W-1:0];

  // Control state and table count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  // Held triangle, sweep position and pending result.
  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
  end

  // Next state, memory control and result selection.
  always_comb begin
    state_nxt   = state_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmp_v_nxt   = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          a_nxt = in_ch.vert_a;
          b_nxt = in_ch.vert_b;
          c_nxt = in_ch.vert_c;
          idx_nxt = '0;
          slot_nxt = '0;
          if (in_ch.operation == OP_CLEAR) begin
            count_nxt  = '0;
            status_nxt = STAT_CLEARED;
            state_nxt  = S_EMIT;
          end else if (degenerate) begin
            status_nxt = STAT_DEGENERATE;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_v_r && hit) begin
          // First matching entry, lowest slot wins.
          status_nxt = STAT_DUPLICATE;
          slot_nxt   = cmp_idx_ext[SLOT_W-1:0];
          state_nxt  = S_EMIT;
        end else if (idx_r < count_r) begin
          // Issue the next read; its data is compared next cycle.
          ram_re      = 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + CW'(1);
        end else if (count_r == CW'(MAX_FACES)) begin
          status_nxt = STAT_FULL;
          slot_nxt   = '0;
          state_nxt  = S_EMIT;
        end else begin
          // No match: append at the current count.
          ram_we     = 1'b1;
          status_nxt = STAT_ADDED;
          slot_nxt   = count_ext[SLOT_W-1:0];
          count_nxt  = count_r + CW'(1);
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/triangle_dedup_table.sv
// A clear or degenerate item goes from its taken beat straight to the result state; an insert
// first sweeps the N stored triangles, one entry per cycle on the memory read port, and stops
// at the first match. Every result then passes through the output register. No new item is taken
// until the sequencer has handed the last result to the output register.
// Reset empties the table (count zero); memory contents are not cleared and are never
// read above the count.
module triangle_dedup_table #(
  parameter int MAX_FACES = 256
) (
  input logic       clk,
  input logic       rst_n,
  tdt_in_if.sink    in_ch,
  tdt_out_if.source out_ch
);
  import tdt_pkg::*;

  logic     res_valid;
  logic     res_ready;
  tdt_res_t res;
  logic     out_valid_r, out_valid_nxt;
  tdt_res_t out_res_r, out_res_nxt;
  logic     res_take;

  tdt_ctrl #(
    .MAX_FACES (MAX_FACES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_o     (res)
  );

  // Output register: holds a finished beat while the sequencer moves on.
  assign res_ready = !out_valid_r || out_ch.ready;
  assign res_take  = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_res_r.status;
  assign out_ch.slot   = out_res_r.slot;
  assign out_ch.count  = out_res_r.count;

  // An added triangle lands at the slot just below the new count.
  a_added_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status == STAT_ADDED) |->
      ((res.slot + SLOT_W'(1)) == res.count[SLOT_W-1:0]))
    else $error("added slot does not match new count");

  // A clear reports an empty table.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status == STAT_CLEARED) |-> (res.count == '0) && (res.slot == '0))
    else $error("clear result not empty");

  // Rejected inserts carry slot zero.
  a_reject_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && ((res.status == STAT_DEGENERATE) || (res.status == STAT_FULL)) |->
      (res.slot == '0))
    else $error("rejected insert has nonzero slot");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second item taken while one is in work");

endmodule
